/* src/lhi_pkg.sv */
// Package: sizes, codes and memory port types for the hash index.
`default_nettype none

package lhi_pkg;

   localparam int LOG_NODES     = 10;
   localparam int NODE_CAPACITY = 1 << LOG_NODES;
   localparam int SLOT_COUNT    = 4 * NODE_CAPACITY;
   localparam int LOG_SLOTS     = LOG_NODES + 2;
   localparam int KEY_W         = 64;
   localparam int INDEX_W       = 10;
   localparam int COUNT_W       = LOG_NODES + 1;

   typedef logic [1:0] req_code_type;
   localparam req_code_type REQ_LOOKUP = 2'd0;
   localparam req_code_type REQ_INSERT = 2'd1;
   localparam req_code_type REQ_CLEAR  = 2'd2;

   typedef logic [1:0] status_type;
   localparam status_type ST_OK        = 2'd0;
   localparam status_type ST_NOT_FOUND = 2'd1;
   localparam status_type ST_DUPLICATE = 2'd2;
   localparam status_type ST_FULL      = 2'd3;

   typedef struct packed {
      logic                 valid;
      logic [LOG_NODES-1:0] node;
   } slot_entry_type;

   typedef struct packed {
      logic                 rd_en;
      logic [LOG_SLOTS-1:0] rd_addr;
      logic                 wr_en;
      logic [LOG_SLOTS-1:0] wr_addr;
      slot_entry_type       wr_data;
   } slot_port_type;

   typedef struct packed {
      logic                 rd_en;
      logic [LOG_NODES-1:0] rd_addr;
      logic                 wr_en;
      logic [LOG_NODES-1:0] wr_addr;
      logic [KEY_W-1:0]     wr_data;
   } key_port_type;

endpackage

`default_nettype wire

/* src/lhi_channels.sv */
// Interfaces: request and response channels with valid/ready handshake.
`default_nettype none

interface lhi_req_if import lhi_pkg::*; ();
   logic             valid;
   logic             ready;
   req_code_type     req_type;
   logic [KEY_W-1:0] key;

   modport source (output valid, req_type, key, input ready);
   modport sink   (input valid, req_type, key, output ready);
endinterface

interface lhi_rsp_if import lhi_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               found;
   logic [INDEX_W-1:0] node_index;
   status_type         status;

   modport source (output valid, found, node_index, status, input ready);
   modport sink   (input valid, found, node_index, status, output ready);
endinterface

`default_nettype wire

/* src/lhi_slot_ram.sv */
// Slot table memory: one write and one registered read port.
`default_nettype none

module lhi_slot_ram import lhi_pkg::*; (
   input  logic           clock,
   input  slot_port_type  ctrl,
   output slot_entry_type rd_data
);

   slot_entry_type mem [SLOT_COUNT];
   slot_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         mem[ctrl.wr_addr] <= ctrl.wr_data;
      end
      if (ctrl.rd_en) begin
         rd_data_ff <= mem[ctrl.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* src/lhi_key_ram.sv */
// Node key store: one write and one registered read port.
`default_nettype none

module lhi_key_ram import lhi_pkg::*; (
   input  logic             clock,
   input  key_port_type     ctrl,
   output logic [KEY_W-1:0] rd_data
);

   logic [KEY_W-1:0] mem [NODE_CAPACITY];
   logic [KEY_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         mem[ctrl.wr_addr] <= ctrl.wr_data;
      end
      if (ctrl.rd_en) begin
         rd_data_ff <= mem[ctrl.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* src/linear_probe_hash_index_core.sv */
// Top level: linear-probing hash index over a node key store.
// Usage:
//   req_chan carries req_type (lookup, insert, clear) and a 64-bit key; one
//   request is taken per transfer when valid and ready are both high.
//   rsp_chan returns exactly one result per request: found, node_index and
//   status, held in an output register until the receiver takes it.
// Sequence: each probe step is a slot table read and, if the slot is
//   occupied, a key read and compare. A request ends on a key match, on an
//   empty slot or after the whole table is walked; its result then passes
//   through the result state into the output register. The next request
//   is taken the cycle after the result is loaded, so requests are served
//   one at a time; the serial slot-then-key memory loop sets the pace.
// Clear: sweeps every slot of the slot table one slot per cycle, then
//   zeroes the node count and produces a result.
// Reset: synchronous; the same sweep runs after reset with req_chan.ready
//   low and no result produced.
// Stall: a finished result waits in the output register; the next request
//   is taken meanwhile, and its result waits until the register drains.
`default_nettype none

module linear_probe_hash_index_core import lhi_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   lhi_req_if.sink  req_chan,
   lhi_rsp_if.source rsp_chan
);

   // controller states
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SLOT  = 3'd1; // slot read data valid this cycle
   localparam logic [2:0] S_KEY   = 3'd2; // key read data valid this cycle
   localparam logic [2:0] S_CLEAR = 3'd3; // slot table sweep
   localparam logic [2:0] S_DONE  = 3'd4; // result waits for output register

   logic [2:0]           state_ff,     state_in;
   req_code_type         type_ff,      type_in;
   logic [KEY_W-1:0]     key_ff,       key_in;
   logic [LOG_SLOTS-1:0] idx_ff,       idx_in;
   logic [LOG_SLOTS-1:0] probes_ff,    probes_in;
   logic [LOG_NODES-1:0] node_ff,      node_in;
   logic [COUNT_W-1:0]   count_ff,     count_in;
   logic [LOG_SLOTS-1:0] sweep_ff,     sweep_in;
   logic                 clr_rsp_ff,   clr_rsp_in;
   logic                 res_found_ff, res_found_in;
   logic [LOG_NODES-1:0] res_index_ff, res_index_in;
   status_type           res_status_ff, res_status_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_found_ff, rsp_found_in;
   logic [INDEX_W-1:0]   rsp_index_ff, rsp_index_in;
   status_type           rsp_status_ff, rsp_status_in;

   slot_port_type        slot_port;
   slot_entry_type       slot_rd;
   key_port_type         key_port;
   logic [KEY_W-1:0]     key_rd;
   logic                 req_ready;

   lhi_slot_ram u_slot_ram (
      .clock   (clock),
      .ctrl    (slot_port),
      .rd_data (slot_rd)
   );

   lhi_key_ram u_key_ram (
      .clock   (clock),
      .ctrl    (key_port),
      .rd_data (key_rd)
   );

   always_comb begin
      state_in      = state_ff;
      type_in       = type_ff;
      key_in        = key_ff;
      idx_in        = idx_ff;
      probes_in     = probes_ff;
      node_in       = node_ff;
      count_in      = count_ff;
      sweep_in      = sweep_ff;
      clr_rsp_in    = clr_rsp_ff;
      res_found_in  = res_found_ff;
      res_index_in  = res_index_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_status_in = rsp_status_ff;
      slot_port     = '0;
      key_port      = '0;
      req_ready     = 1'b0;

      // output register drains on a transfer
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_chan.valid) begin
               type_in       = req_chan.req_type;
               key_in        = req_chan.key;
               idx_in        = req_chan.key[LOG_SLOTS-1:0];
               probes_in     = '0;
               res_found_in  = 1'b0;
               res_index_in  = '0;
               res_status_in = ST_OK;
               case (req_chan.req_type)
                  REQ_LOOKUP, REQ_INSERT: begin
                     slot_port.rd_en   = 1'b1;
                     slot_port.rd_addr = req_chan.key[LOG_SLOTS-1:0];
                     state_in          = S_SLOT;
                  end
                  REQ_CLEAR: begin
                     sweep_in   = '0;
                     clr_rsp_in = 1'b1;
                     state_in   = S_CLEAR;
                  end
                  default: begin
                     // unused code: empty result, tables and node count untouched
                     state_in = S_DONE;
                  end
               endcase
            end
         end

         S_SLOT: begin
            if (!slot_rd.valid) begin
               // empty slot ends the chain: miss, or insert point
               if (type_ff == REQ_LOOKUP) begin
                  res_status_in = ST_NOT_FOUND;
               end else if (count_ff >= COUNT_W'(NODE_CAPACITY)) begin
                  res_status_in = ST_FULL;
               end else begin
                  key_port.wr_en          = 1'b1;
                  key_port.wr_addr        = count_ff[LOG_NODES-1:0];
                  key_port.wr_data        = key_ff;
                  slot_port.wr_en         = 1'b1;
                  slot_port.wr_addr       = idx_ff;
                  slot_port.wr_data.valid = 1'b1;
                  slot_port.wr_data.node  = count_ff[LOG_NODES-1:0];
                  count_in                = count_ff + COUNT_W'(1);
                  res_index_in            = count_ff[LOG_NODES-1:0];
               end
               state_in = S_DONE;
            end else begin
               key_port.rd_en   = 1'b1;
               key_port.rd_addr = slot_rd.node;
               node_in          = slot_rd.node;
               state_in         = S_KEY;
            end
         end

         S_KEY: begin
            if (key_rd == key_ff) begin
               res_found_in  = 1'b1;
               res_index_in  = node_ff;
               res_status_in = (type_ff == REQ_INSERT) ? ST_DUPLICATE : ST_OK;
               state_in      = S_DONE;
            end else if (probes_ff == '1) begin
               // whole table walked without an empty slot
               res_status_in = (type_ff == REQ_LOOKUP) ? ST_NOT_FOUND : ST_FULL;
               state_in      = S_DONE;
            end else begin
               idx_in            = idx_ff + LOG_SLOTS'(1);
               probes_in         = probes_ff + LOG_SLOTS'(1);
               slot_port.rd_en   = 1'b1;
               slot_port.rd_addr = idx_ff + LOG_SLOTS'(1);
               state_in          = S_SLOT;
            end
         end

         S_CLEAR: begin
            slot_port.wr_en   = 1'b1;
            slot_port.wr_addr = sweep_ff;
            slot_port.wr_data = '0;
            sweep_in          = sweep_ff + LOG_SLOTS'(1);
            if (sweep_ff == '1) begin
               count_in = '0;
               state_in = clr_rsp_ff ? S_DONE : S_IDLE;
            end
         end

         S_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_found_in  = res_found_ff;
               rsp_index_in  = INDEX_W'(res_index_ff);
               rsp_status_in = res_status_ff;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         sweep_ff     <= '0;
         clr_rsp_ff   <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         clr_rsp_ff   <= clr_rsp_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      type_ff       <= type_in;
      key_ff        <= key_in;
      idx_ff        <= idx_in;
      probes_ff     <= probes_in;
      node_ff       <= node_in;
      res_found_ff  <= res_found_in;
      res_index_ff  <= res_index_in;
      res_status_ff <= res_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign req_chan.ready      = req_ready;
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.found      = rsp_found_ff;
   assign rsp_chan.node_index = rsp_index_ff;
   assign rsp_chan.status     = rsp_status_ff;

`ifndef ASSERT_OFF
   // node count stays within the store
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(NODE_CAPACITY))
      else $error("node count beyond store size");

   // slot data is only examined the cycle after a slot read
   a_slot_read_fresh: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SLOT) |-> $past(slot_port.rd_en))
      else $error("slot data used without a read");

   // an insert only links into a slot seen empty
   a_insert_empty: assert property (@(posedge clock) disable iff (reset)
      (slot_port.wr_en && state_ff == S_SLOT) |-> !slot_rd.valid)
      else $error("insert overwrote an occupied slot");

   // a result appears only out of the result state
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("result raised outside result state");
`endif

endmodule

`default_nettype wire
